FILE: hdl/quad_clip_bilinear_interp_macros.svh
// ---------------------------------------------------------------------------
// quad_clip_bilinear_interp assertion macros
// Shared property shorthands for the clip/interpolation block.
// ---------------------------------------------------------------------------
`ifndef QUAD_CLIP_BILINEAR_INTERP_MACROS_SVH
`define QUAD_CLIP_BILINEAR_INTERP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define QCBI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define QCBI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/qcbi_pkg.sv
// ---------------------------------------------------------------------------
// qcbi_pkg
// Types, register codes and interpolation helpers for the quad clip block.
// ---------------------------------------------------------------------------
package qcbi_pkg;

    localparam int COORD_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int COLOUR_W = 8;
    localparam int LERP_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * (LERP_W + 1);

    typedef logic [FRAC_W:0] frac_t;

    localparam frac_t FRAC_ZERO = '0;
    localparam frac_t FRAC_ONE  = {1'b1, {FRAC_W{1'b0}}};

    typedef enum logic [3:0] {
        REG_QUAD_LT   = 4'd0,
        REG_QUAD_RB   = 4'd1,
        REG_TEX_LT    = 4'd2,
        REG_TEX_RB    = 4'd3,
        REG_COLOUR_LT = 4'd4,
        REG_COLOUR_RT = 4'd5,
        REG_COLOUR_LB = 4'd6,
        REG_COLOUR_RB = 4'd7
    } reg_index_t;

    localparam logic [1:0] CORNER_LT = 2'd0;
    localparam logic [1:0] CORNER_LB = 2'd1;
    localparam logic [1:0] CORNER_RT = 2'd2;
    localparam logic [1:0] CORNER_RB = 2'd3;

    typedef struct packed {
        logic                       clip_enable;
        logic signed [COORD_W-1:0]  clip_left;
        logic signed [COORD_W-1:0]  clip_top;
        logic signed [COORD_W-1:0]  clip_right;
        logic signed [COORD_W-1:0]  clip_bottom;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                 corner;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  tex_u;
        logic signed [COORD_W-1:0]  tex_v;
        logic [COLOUR_W-1:0]        red;
        logic [COLOUR_W-1:0]        green;
        logic [COLOUR_W-1:0]        blue;
        logic [COLOUR_W-1:0]        alpha;
        logic                       last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  u;
        logic signed [COORD_W-1:0]  v;
        logic [COLOUR_W-1:0]        r;
        logic [COLOUR_W-1:0]        g;
        logic [COLOUR_W-1:0]        b;
        logic [COLOUR_W-1:0]        a;
    } vtx_t;

    typedef struct packed {
        logic start;
        logic step;
    } div_ctrl_t;

    // a + round(t * (b - a)), halves toward plus infinity
    function automatic logic signed [LERP_W-1:0] lerp1(
        input logic signed [LERP_W-1:0] a,
        input logic signed [LERP_W-1:0] b,
        input frac_t                    t
    );
        logic signed [LERP_W:0]   d;
        logic signed [PROD_W-1:0] p;
        d = (LERP_W+1)'(b) - (LERP_W+1)'(a);
        p = $signed({1'b0, t}) * d;
        p = p + (PROD_W'(1) <<< (FRAC_W - 1));
        return a + p[FRAC_W+LERP_W-1:FRAC_W];
    endfunction

    function automatic logic signed [LERP_W-1:0] cext(input logic [COLOUR_W-1:0] c);
        return LERP_W'($signed({1'b0, c}));
    endfunction

    function automatic vtx_t lerp_vtx(input vtx_t a, input vtx_t b, input frac_t t);
        vtx_t r;
        r.x = COORD_W'(lerp1(LERP_W'(a.x), LERP_W'(b.x), t));
        r.y = COORD_W'(lerp1(LERP_W'(a.y), LERP_W'(b.y), t));
        r.u = COORD_W'(lerp1(LERP_W'(a.u), LERP_W'(b.u), t));
        r.v = COORD_W'(lerp1(LERP_W'(a.v), LERP_W'(b.v), t));
        r.r = COLOUR_W'(lerp1(cext(a.r), cext(b.r), t));
        r.g = COLOUR_W'(lerp1(cext(a.g), cext(b.g), t));
        r.b = COLOUR_W'(lerp1(cext(a.b), cext(b.b), t));
        r.a = COLOUR_W'(lerp1(cext(a.a), cext(b.a), t));
        return r;
    endfunction

endpackage

FILE: hdl/qcbi_div_lane.sv
// ---------------------------------------------------------------------------
// qcbi_div_lane
// One fraction lane: clamped (pos - lo) / (hi - lo) in Q1.16, 4 bits a cycle while ctrl.step is set.
// ---------------------------------------------------------------------------
module qcbi_div_lane (
    input  logic                                  aclk,
    input  qcbi_pkg::div_ctrl_t                   ctrl,
    input  logic signed [qcbi_pkg::COORD_W-1:0]   pos,
    input  logic signed [qcbi_pkg::COORD_W-1:0]   lo,
    input  logic signed [qcbi_pkg::COORD_W-1:0]   hi,
    output qcbi_pkg::frac_t                       frac
);
    import qcbi_pkg::*;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_DIV  = 2'd2;
    localparam int STEPS = 4;

    logic [1:0]          mode_reg;
    logic [COORD_W-1:0]  rem_reg, rem_next;
    logic [COORD_W-1:0]  low_reg, low_next;
    logic [COORD_W-1:0]  quo_reg, quo_next;
    logic [COORD_W-1:0]  w_reg;
    logic signed [COORD_W:0] w_full, n_full;
    logic [COORD_W:0]    trial;

    assign w_full = (COORD_W+1)'(hi) - (COORD_W+1)'(lo);
    assign n_full = (COORD_W+1)'(pos) - (COORD_W+1)'(lo);

    // restoring long division; in MODE_DIV the remainder stays below the width
    always_comb begin
        rem_next = rem_reg;
        low_next = low_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < STEPS; i++) begin
            trial    = {rem_next, low_next[COORD_W-1]};
            low_next = {low_next[COORD_W-2:0], 1'b0};
            if (trial >= {1'b0, w_reg}) begin
                rem_next = COORD_W'(trial - {1'b0, w_reg});
                quo_next = {quo_next[COORD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[COORD_W-1:0];
                quo_next = {quo_next[COORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            if (w_full <= 0 || n_full <= 0) begin
                mode_reg <= MODE_ZERO;
            end else if (n_full >= w_full) begin
                mode_reg <= MODE_FULL;
            end else begin
                mode_reg <= MODE_DIV;
            end
            rem_reg <= n_full[COORD_W-1:0];
            low_reg <= w_full[COORD_W:1];
            w_reg   <= w_full[COORD_W-1:0];
            quo_reg <= '0;
        end else if (ctrl.step) begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
        end
    end

    always_comb begin
        case (mode_reg)
            MODE_FULL: frac = FRAC_ONE;
            MODE_DIV:  frac = {1'b0, quo_reg};
            default:   frac = FRAC_ZERO;
        endcase
    end

endmodule

FILE: hdl/qcbi_lerp_stage.sv
// ---------------------------------------------------------------------------
// qcbi_lerp_stage
// Registered linear blend of two vertices across all eight channels.
// ---------------------------------------------------------------------------
module qcbi_lerp_stage (
    input  logic             aclk,
    input  logic             en,
    input  qcbi_pkg::vtx_t   a,
    input  qcbi_pkg::vtx_t   b,
    input  qcbi_pkg::frac_t  t,
    output qcbi_pkg::vtx_t   q
);
    import qcbi_pkg::*;

    vtx_t q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= lerp_vtx(a, b, t);
        end
    end

    assign q = q_reg;

endmodule

FILE: hdl/quad_clip_bilinear_interp.sv
// ---------------------------------------------------------------------------
// quad_clip_bilinear_interp
// Clips a textured, corner-coloured quad to a rectangle and emits 4 vertices.
// ---------------------------------------------------------------------------
//  channel   ports                        payload
//  input     s_valid / s_ready / s_data   in_item_t, one clip rectangle
//  result    m_valid / m_ready / m_data   out_item_t, four per transaction
//  config    cfg_valid/cfg_ready          cfg_addr (index), cfg_data (32 bits)
//
//  an input is accepted only while the lanes are not busy: the accept loads the four
//  divider lanes, then each step retires 4 quotient bits; the vertices of the last
//  quad may still be leaving the result channel while the next input is accepted
//  the first vertex leaves through the select, horizontal and vertical blend registers
//  aresetn clears control state and sets the config registers to their reset values
//  a stalled result channel freezes the vertex pipe; the lanes keep working
// ---------------------------------------------------------------------------
module quad_clip_bilinear_interp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qcbi_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output qcbi_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_addr,
    input  logic [31:0]          cfg_data
);
    import qcbi_pkg::*;

    localparam int LANES = 4;
    localparam int DIV_CYCLES = 4;

    // config registers
    logic [31:0] quad_lt_reg, quad_rb_reg, tex_lt_reg, tex_rb_reg;
    logic [31:0] col_lt_reg, col_rt_reg, col_lb_reg, col_rb_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_lt_reg <= 32'h0000_0000;
            quad_rb_reg <= 32'h0000_0000;
            tex_lt_reg  <= 32'h0000_0000;
            tex_rb_reg  <= 32'h4000_4000;
            col_lt_reg  <= 32'hFFFF_FFFF;
            col_rt_reg  <= 32'hFFFF_FFFF;
            col_lb_reg  <= 32'hFFFF_FFFF;
            col_rb_reg  <= 32'hFFFF_FFFF;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_QUAD_LT:   quad_lt_reg <= cfg_data;
                REG_QUAD_RB:   quad_rb_reg <= cfg_data;
                REG_TEX_LT:    tex_lt_reg  <= cfg_data;
                REG_TEX_RB:    tex_rb_reg  <= cfg_data;
                REG_COLOUR_LT: col_lt_reg  <= cfg_data;
                REG_COLOUR_RT: col_rt_reg  <= cfg_data;
                REG_COLOUR_LB: col_lb_reg  <= cfg_data;
                REG_COLOUR_RB: col_rb_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [COORD_W-1:0] q_l, q_t, q_r, q_b, t_u1, t_v1, t_u2, t_v2;
    vtx_t vtx_lt, vtx_lb, vtx_rt, vtx_rb;

    assign q_l  = quad_lt_reg[15:0];
    assign q_t  = quad_lt_reg[31:16];
    assign q_r  = quad_rb_reg[15:0];
    assign q_b  = quad_rb_reg[31:16];
    assign t_u1 = tex_lt_reg[15:0];
    assign t_v1 = tex_lt_reg[31:16];
    assign t_u2 = tex_rb_reg[15:0];
    assign t_v2 = tex_rb_reg[31:16];

    assign vtx_lt = '{x: q_l, y: q_t, u: t_u1, v: t_v1, r: col_lt_reg[7:0],
                      g: col_lt_reg[15:8], b: col_lt_reg[23:16], a: col_lt_reg[31:24]};
    assign vtx_lb = '{x: q_l, y: q_b, u: t_u1, v: t_v2, r: col_lb_reg[7:0],
                      g: col_lb_reg[15:8], b: col_lb_reg[23:16], a: col_lb_reg[31:24]};
    assign vtx_rt = '{x: q_r, y: q_t, u: t_u2, v: t_v1, r: col_rt_reg[7:0],
                      g: col_rt_reg[15:8], b: col_rt_reg[23:16], a: col_rt_reg[31:24]};
    assign vtx_rb = '{x: q_r, y: q_b, u: t_u2, v: t_v2, r: col_rb_reg[7:0],
                      g: col_rb_reg[15:8], b: col_rb_reg[23:16], a: col_rb_reg[31:24]};

    // divider lanes: left x, right x, top y, bottom y
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [1:0]                 cnt_reg, cnt_next;
    logic                       en_reg;
    logic                       accept, take;
    div_ctrl_t                  div_ctrl;
    logic signed [COORD_W-1:0]  lane_pos [LANES];
    logic signed [COORD_W-1:0]  lane_lo  [LANES];
    logic signed [COORD_W-1:0]  lane_hi  [LANES];
    frac_t                      lane_frac [LANES];

    assign s_ready = !busy_reg && (!done_reg || take);
    assign accept  = s_valid && s_ready;
    assign div_ctrl = '{start: accept, step: busy_reg};

    assign lane_pos[0] = s_data.clip_left;
    assign lane_pos[1] = s_data.clip_right;
    assign lane_pos[2] = s_data.clip_top;
    assign lane_pos[3] = s_data.clip_bottom;
    assign lane_lo[0]  = q_l;
    assign lane_lo[1]  = q_l;
    assign lane_lo[2]  = q_t;
    assign lane_lo[3]  = q_t;
    assign lane_hi[0]  = q_r;
    assign lane_hi[1]  = q_r;
    assign lane_hi[2]  = q_b;
    assign lane_hi[3]  = q_b;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        qcbi_div_lane u_lane (
            .aclk (aclk),
            .ctrl (div_ctrl),
            .pos  (lane_pos[g]),
            .lo   (lane_lo[g]),
            .hi   (lane_hi[g]),
            .frac (lane_frac[g])
        );
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        if (take) begin
            done_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'(DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            en_reg <= s_data.clip_enable;
        end
    end

    // merge: sequence the four corners from the lane fractions
    logic        advance;
    logic        seq_active_reg, seq_active_next;
    logic [1:0]  vcnt_reg, vcnt_next;
    frac_t       txl_reg, txr_reg, tyt_reg, tyb_reg;

    assign advance = !m_valid || m_ready;
    assign take    = done_reg && (!seq_active_reg || (advance && vcnt_reg == CORNER_RB));

    always_comb begin
        seq_active_next = seq_active_reg;
        vcnt_next       = vcnt_reg;
        if (seq_active_reg && advance) begin
            vcnt_next = vcnt_reg + 2'd1;
            if (vcnt_reg == CORNER_RB) begin
                seq_active_next = 1'b0;
            end
        end
        if (take) begin
            seq_active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_active_reg <= 1'b0;
            vcnt_reg       <= '0;
        end else begin
            seq_active_reg <= seq_active_next;
            vcnt_reg       <= vcnt_next;
        end
    end

    // with clipping off the fractions pick the quad corners themselves
    always_ff @(posedge aclk) begin
        if (take) begin
            txl_reg <= en_reg ? lane_frac[0] : FRAC_ZERO;
            txr_reg <= en_reg ? lane_frac[1] : FRAC_ONE;
            tyt_reg <= en_reg ? lane_frac[2] : FRAC_ZERO;
            tyb_reg <= en_reg ? lane_frac[3] : FRAC_ONE;
        end
    end

    // vertex pipe: select, horizontal blend, vertical blend
    logic        v1_reg, v2_reg, v3_reg;
    logic [1:0]  corner1_reg, corner2_reg, corner3_reg;
    frac_t       tx1_reg, ty1_reg, ty2_reg;
    vtx_t        top2, bot2, out3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= seq_active_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            corner1_reg <= vcnt_reg;
            tx1_reg     <= vcnt_reg[1] ? txr_reg : txl_reg;
            ty1_reg     <= vcnt_reg[0] ? tyb_reg : tyt_reg;
            corner2_reg <= corner1_reg;
            ty2_reg     <= ty1_reg;
            corner3_reg <= corner2_reg;
        end
    end

    qcbi_lerp_stage u_top (
        .aclk (aclk), .en (advance), .a (vtx_lt), .b (vtx_rt), .t (tx1_reg), .q (top2)
    );

    qcbi_lerp_stage u_bot (
        .aclk (aclk), .en (advance), .a (vtx_lb), .b (vtx_rb), .t (tx1_reg), .q (bot2)
    );

    qcbi_lerp_stage u_vert (
        .aclk (aclk), .en (advance), .a (top2), .b (bot2), .t (ty2_reg), .q (out3)
    );

    assign m_valid = v3_reg;
    assign m_data  = '{corner: corner3_reg, pos_x: out3.x, pos_y: out3.y,
                       tex_u: out3.u, tex_v: out3.v, red: out3.r, green: out3.g,
                       blue: out3.b, alpha: out3.a, last: (corner3_reg == CORNER_RB)};

`include "quad_clip_bilinear_interp_macros.svh"

    `QCBI_ASSERT_SAME(a_busy_done_excl, aclk, aresetn, busy_reg, !done_reg, "busy and done")
    `QCBI_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, busy_reg, "lanes idle")
    `QCBI_ASSERT_SAME(a_take_on_last, aclk, aresetn, take && seq_active_reg, vcnt_reg == CORNER_RB, "take mid-run")
    `QCBI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "vertex moved")

endmodule
